// ----- sv/nfcs_pkg.sv -----
`default_nettype none
package nfcs_pkg;

   localparam int unsigned WORD_ADDRESS_BITS_DEF = 21;
   localparam int unsigned POLL_COUNT_BITS_DEF   = 24;
   localparam int unsigned QUEUE_DEPTH           = 4;

   localparam int unsigned OFFSET_BITS = 22;
   localparam int unsigned WORD_BITS   = 16;
   localparam int unsigned LIMIT_BITS  = 24;
   localparam int unsigned SEQ_BITS    = 3;
   localparam int unsigned STEP_BITS   = 3;
   localparam int unsigned CSR_ADDR_BITS = 4;

   localparam logic [LIMIT_BITS-1:0] POLL_LIMIT_RESET       = 24'hFFFFFF;
   localparam logic [WORD_BITS-1:0]  EXPECTED_VENDOR_RESET  = 16'h00BF;
   localparam logic [WORD_BITS-1:0]  EXPECTED_PRODUCT_RESET = 16'h235B;

   localparam logic [WORD_BITS-1:0] UNLOCK_A      = 16'h5555;
   localparam logic [WORD_BITS-1:0] UNLOCK_B      = 16'h2AAA;
   localparam logic [WORD_BITS-1:0] UNLOCK_DATA_A = 16'h00AA;
   localparam logic [WORD_BITS-1:0] UNLOCK_DATA_B = 16'h0055;
   localparam logic [WORD_BITS-1:0] CMD_ID_ENTRY  = 16'h0090;
   localparam logic [WORD_BITS-1:0] CMD_ID_EXIT   = 16'h00F0;
   localparam logic [WORD_BITS-1:0] CMD_ERASE     = 16'h0080;
   localparam logic [WORD_BITS-1:0] CMD_SECTOR    = 16'h0030;
   localparam logic [WORD_BITS-1:0] CMD_PROGRAM   = 16'h00A0;
   localparam int unsigned          DQ6_BIT       = 6;

   typedef enum logic [1:0] {
      OP_PROGRAM  = 2'd0,
      OP_ERASE    = 2'd1,
      OP_READ_ID  = 2'd2,
      OP_RESPONSE = 2'd3
   } nfcs_op_type;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_DONE  = 2'd2
   } nfcs_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TIMEOUT = 2'd1,
      ST_UNKNOWN = 2'd2
   } nfcs_status_type;

   typedef enum logic [1:0] {
      REG_POLL_LIMIT       = 2'd0,
      REG_EXPECTED_VENDOR  = 2'd1,
      REG_EXPECTED_PRODUCT = 2'd2,
      REG_NONE             = 2'd3
   } nfcs_reg_type;

   // job codes carried through the queue; each expands into a fixed beat list
   typedef enum logic [SEQ_BITS-1:0] {
      SEQ_PROGRAM = 3'd0,
      SEQ_ERASE   = 3'd1,
      SEQ_READ_ID = 3'd2,
      SEQ_READ    = 3'd3,
      SEQ_DONE    = 3'd4,
      SEQ_ID_EXIT = 3'd5
   } nfcs_seq_type;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] poll_limit;
      logic [WORD_BITS-1:0]  expected_vendor;
      logic [WORD_BITS-1:0]  expected_product;
   } nfcs_cfg_type;

   typedef struct packed {
      nfcs_kind_type        kind;
      logic                 addr_from_job;
      logic [WORD_BITS-1:0] addr_const;
      logic                 data_from_job;
      logic [WORD_BITS-1:0] data_const;
      logic                 last;
   } nfcs_beat_type;

   function automatic nfcs_beat_type nfcs_write(input logic [WORD_BITS-1:0] addr,
                                                input logic [WORD_BITS-1:0] data);
      nfcs_beat_type b;
      b.kind          = KIND_WRITE;
      b.addr_from_job = 1'b0;
      b.addr_const    = addr;
      b.data_from_job = 1'b0;
      b.data_const    = data;
      b.last          = 1'b0;
      return b;
   endfunction

   function automatic nfcs_beat_type nfcs_unlock(input logic [STEP_BITS-1:0] step,
                                                 input logic [WORD_BITS-1:0] cmd);
      nfcs_beat_type b;
      case (step)
         3'd0:    b = nfcs_write(UNLOCK_A, UNLOCK_DATA_A);
         3'd1:    b = nfcs_write(UNLOCK_B, UNLOCK_DATA_B);
         default: b = nfcs_write(UNLOCK_A, cmd);
      endcase
      return b;
   endfunction

   // beat list of each job
   function automatic nfcs_beat_type nfcs_beat(input nfcs_seq_type seq,
                                               input logic [STEP_BITS-1:0] step);
      nfcs_beat_type b;
      nfcs_beat_type rd_job;
      nfcs_beat_type done;
      rd_job = '{kind: KIND_READ, addr_from_job: 1'b1, addr_const: '0,
                 data_from_job: 1'b0, data_const: '0, last: 1'b1};
      done   = '{kind: KIND_DONE, addr_from_job: 1'b0, addr_const: '0,
                 data_from_job: 1'b0, data_const: '0, last: 1'b1};
      case (seq)
         SEQ_PROGRAM: begin
            case (step)
               3'd0, 3'd1, 3'd2: b = nfcs_unlock(step, CMD_PROGRAM);
               3'd3: begin
                  b = nfcs_write('0, '0);
                  b.addr_from_job = 1'b1;
                  b.data_from_job = 1'b1;
               end
               default: b = rd_job;
            endcase
         end
         SEQ_ERASE: begin
            case (step)
               3'd0, 3'd1, 3'd2: b = nfcs_unlock(step, CMD_ERASE);
               3'd3: b = nfcs_write(UNLOCK_A, UNLOCK_DATA_A);
               3'd4: b = nfcs_write(UNLOCK_B, UNLOCK_DATA_B);
               3'd5: begin
                  b = nfcs_write('0, CMD_SECTOR);
                  b.addr_from_job = 1'b1;
               end
               default: b = rd_job;
            endcase
         end
         SEQ_READ_ID: begin
            case (step)
               3'd0, 3'd1, 3'd2: b = nfcs_unlock(step, CMD_ID_ENTRY);
               default: begin
                  b = rd_job;
                  b.addr_from_job = 1'b0;
               end
            endcase
         end
         SEQ_READ: b = rd_job;
         SEQ_ID_EXIT: begin
            case (step)
               3'd0, 3'd1, 3'd2: b = nfcs_unlock(step, CMD_ID_EXIT);
               default: b = done;
            endcase
         end
         default: b = done;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ----- sv/nfcs_if.sv -----
`default_nettype none
interface nfcs_req_if;
   import nfcs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             operation;
   logic [OFFSET_BITS-1:0] byte_offset;
   logic [WORD_BITS-1:0]   write_data;
   logic [WORD_BITS-1:0]   read_data;

   modport source (output valid, operation, byte_offset, write_data, read_data,
                   input ready);
   modport sink   (input valid, operation, byte_offset, write_data, read_data,
                   output ready);
endinterface

interface nfcs_rsp_if #(
   parameter int unsigned WORD_ADDRESS_BITS = nfcs_pkg::WORD_ADDRESS_BITS_DEF
);
   import nfcs_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [1:0]                   item_kind;
   logic [WORD_ADDRESS_BITS-1:0] bus_address;
   logic [WORD_BITS-1:0]         bus_data;
   logic [1:0]                   status;
   logic [WORD_BITS-1:0]         vendor_id;
   logic [WORD_BITS-1:0]         product_id;
   logic                         last;

   modport source (output valid, item_kind, bus_address, bus_data, status,
                   vendor_id, product_id, last, input ready);
   modport sink   (input valid, item_kind, bus_address, bus_data, status,
                   vendor_id, product_id, last, output ready);
endinterface
`default_nettype wire

// ----- sv/nfcs_front.sv -----
`default_nettype none
module nfcs_front #(
   parameter int unsigned WORD_ADDRESS_BITS = nfcs_pkg::WORD_ADDRESS_BITS_DEF,
   parameter int unsigned POLL_COUNT_BITS   = nfcs_pkg::POLL_COUNT_BITS_DEF,
   parameter int unsigned JOB_BITS          = nfcs_pkg::SEQ_BITS + WORD_ADDRESS_BITS
                                              + 3 * nfcs_pkg::WORD_BITS + 2
) (
   input  wire                       clock,
   input  wire                       reset,
   nfcs_req_if.sink                  req,
   input  wire nfcs_pkg::nfcs_cfg_type cfg,
   input  wire                       queue_full,
   output logic                      push,
   output logic [JOB_BITS-1:0]       push_data
);
   import nfcs_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_POLL,
      PH_VENDOR,
      PH_PRODUCT
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [WORD_ADDRESS_BITS-1:0] target_ff, target_in;
   logic                         prev_bit_ff, prev_bit_in;
   logic                         have_first_ff, have_first_in;
   logic [POLL_COUNT_BITS-1:0]   count_ff, count_in;
   logic [WORD_BITS-1:0]         vendor_ff, vendor_in;

   logic                         accept;
   logic [31:0]                  waddr_wide;
   logic [WORD_ADDRESS_BITS-1:0] waddr;
   logic                         dq6;
   logic [POLL_COUNT_BITS-1:0]   count_next;

   nfcs_seq_type                 job_seq;
   logic [WORD_ADDRESS_BITS-1:0] job_addr;
   nfcs_status_type              job_status;
   logic [WORD_BITS-1:0]         job_vendor;
   logic [WORD_BITS-1:0]         job_product;

   assign req.ready  = ~queue_full;
   assign accept     = req.valid & ~queue_full;
   assign waddr_wide = {11'b0, req.byte_offset[OFFSET_BITS-1:1]};
   assign waddr      = waddr_wide[WORD_ADDRESS_BITS-1:0];
   assign dq6        = req.read_data[DQ6_BIT];
   assign count_next = have_first_ff ? count_ff + POLL_COUNT_BITS'(1) : count_ff;

   always_comb begin
      phase_in      = phase_ff;
      target_in     = target_ff;
      prev_bit_in   = prev_bit_ff;
      have_first_in = have_first_ff;
      count_in      = count_ff;
      vendor_in     = vendor_ff;
      push          = 1'b0;
      job_seq       = SEQ_DONE;
      job_addr      = target_ff;
      job_status    = ST_OK;
      job_vendor    = '0;
      job_product   = '0;
      if (accept) begin
         if (nfcs_op_type'(req.operation) != OP_RESPONSE) begin
            if (phase_ff == PH_IDLE) begin
               target_in     = waddr;
               prev_bit_in   = 1'b0;
               have_first_in = 1'b0;
               count_in      = '0;
               push          = 1'b1;
               job_addr      = waddr;
               case (nfcs_op_type'(req.operation))
                  OP_PROGRAM: begin
                     job_seq  = SEQ_PROGRAM;
                     phase_in = PH_POLL;
                  end
                  OP_ERASE: begin
                     job_seq  = SEQ_ERASE;
                     phase_in = PH_POLL;
                  end
                  default: begin
                     job_seq  = SEQ_READ_ID;
                     phase_in = PH_VENDOR;
                  end
               endcase
            end
         end else begin
            case (phase_ff)
               PH_POLL: begin
                  push = 1'b1;
                  if (have_first_ff && dq6 == prev_bit_ff) begin
                     job_seq       = SEQ_DONE;
                     phase_in      = PH_IDLE;
                     have_first_in = 1'b0;
                  end else begin
                     count_in      = count_next;
                     prev_bit_in   = dq6;
                     have_first_in = 1'b1;
                     // limit reached or counter saturated ends the poll
                     if (32'(count_next) >= 32'(cfg.poll_limit) || (&count_next)) begin
                        job_seq       = SEQ_DONE;
                        job_status    = ST_TIMEOUT;
                        phase_in      = PH_IDLE;
                        have_first_in = 1'b0;
                     end else begin
                        job_seq = SEQ_READ;
                     end
                  end
               end
               PH_VENDOR: begin
                  push      = 1'b1;
                  vendor_in = req.read_data;
                  job_seq   = SEQ_READ;
                  job_addr  = WORD_ADDRESS_BITS'(1);
                  phase_in  = PH_PRODUCT;
               end
               PH_PRODUCT: begin
                  push        = 1'b1;
                  job_seq     = SEQ_ID_EXIT;
                  job_vendor  = vendor_ff;
                  job_product = req.read_data;
                  job_status  = (vendor_ff == cfg.expected_vendor &&
                                 req.read_data == cfg.expected_product) ? ST_OK : ST_UNKNOWN;
                  phase_in    = PH_IDLE;
               end
               default: ;
            endcase
         end
      end
   end

   assign push_data = {job_seq, job_addr, req.write_data, job_status, job_vendor, job_product};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         have_first_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         have_first_ff <= have_first_in;
      end
      target_ff   <= target_in;
      prev_bit_ff <= prev_bit_in;
      count_ff    <= count_in;
      vendor_ff   <= vendor_in;
   end

endmodule
`default_nettype wire

// ----- sv/nfcs_queue.sv -----
`default_nettype none
module nfcs_queue #(
   parameter int unsigned DATA_BITS = 8,
   parameter int unsigned DEPTH     = nfcs_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire [DATA_BITS-1:0]  push_data,
   output logic                 full,
   input  wire                  pop,
   output logic                 empty,
   output logic [DATA_BITS-1:0] head
);
   import nfcs_pkg::*;

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push)
         wr_in = (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + PTR_BITS'(1);
      if (do_pop)
         rd_in = (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + PTR_BITS'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CNT_BITS'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push)
         slot_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ----- sv/nfcs_back.sv -----
`default_nettype none
module nfcs_back #(
   parameter int unsigned WORD_ADDRESS_BITS = nfcs_pkg::WORD_ADDRESS_BITS_DEF,
   parameter int unsigned JOB_BITS          = nfcs_pkg::SEQ_BITS + WORD_ADDRESS_BITS
                                              + 3 * nfcs_pkg::WORD_BITS + 2
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 queue_empty,
   input  wire [JOB_BITS-1:0]  queue_head,
   output logic                pop,
   nfcs_rsp_if.source          rsp
);
   import nfcs_pkg::*;

   logic [SEQ_BITS-1:0]          head_seq;
   logic [WORD_ADDRESS_BITS-1:0] head_addr;
   logic [WORD_BITS-1:0]         head_data;
   logic [1:0]                   head_status;
   logic [WORD_BITS-1:0]         head_vendor;
   logic [WORD_BITS-1:0]         head_product;

   logic                         job_valid_ff;
   nfcs_seq_type                 job_seq_ff;
   logic [WORD_ADDRESS_BITS-1:0] job_addr_ff;
   logic [WORD_BITS-1:0]         job_data_ff;
   logic [1:0]                   job_status_ff;
   logic [WORD_BITS-1:0]         job_vendor_ff;
   logic [WORD_BITS-1:0]         job_product_ff;
   logic [STEP_BITS-1:0]         step_ff;

   logic                         rsp_valid_ff;
   nfcs_kind_type                kind_ff;
   logic [WORD_ADDRESS_BITS-1:0] addr_ff;
   logic [WORD_BITS-1:0]         data_ff;
   logic [1:0]                   status_ff;
   logic [WORD_BITS-1:0]         vendor_id_ff;
   logic [WORD_BITS-1:0]         product_id_ff;
   logic                         last_ff;

   nfcs_beat_type                beat;
   logic                         emit;
   logic                         job_done;
   logic                         is_done;

   assign {head_seq, head_addr, head_data, head_status, head_vendor, head_product} = queue_head;

   assign beat     = nfcs_beat(job_seq_ff, step_ff);
   assign emit     = job_valid_ff & (~rsp_valid_ff | rsp.ready);
   assign job_done = emit & beat.last;
   assign pop      = ~queue_empty & (~job_valid_ff | job_done);
   assign is_done  = (beat.kind == KIND_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (pop) begin
            job_valid_ff <= 1'b1;
            step_ff      <= '0;
         end else if (job_done) begin
            job_valid_ff <= 1'b0;
         end else if (emit) begin
            step_ff <= step_ff + STEP_BITS'(1);
         end
         if (emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
      end
      if (pop) begin
         job_seq_ff     <= nfcs_seq_type'(head_seq);
         job_addr_ff    <= head_addr;
         job_data_ff    <= head_data;
         job_status_ff  <= head_status;
         job_vendor_ff  <= head_vendor;
         job_product_ff <= head_product;
      end
      if (emit) begin
         kind_ff       <= beat.kind;
         addr_ff       <= beat.addr_from_job ? job_addr_ff
                                             : WORD_ADDRESS_BITS'(beat.addr_const);
         data_ff       <= beat.data_from_job ? job_data_ff : beat.data_const;
         status_ff     <= is_done ? job_status_ff : 2'(ST_OK);
         vendor_id_ff  <= is_done ? job_vendor_ff : '0;
         product_id_ff <= is_done ? job_product_ff : '0;
         last_ff       <= beat.last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.item_kind   = kind_ff;
   assign rsp.bus_address = addr_ff;
   assign rsp.bus_data    = data_ff;
   assign rsp.status      = status_ff;
   assign rsp.vendor_id   = vendor_id_ff;
   assign rsp.product_id  = product_id_ff;
   assign rsp.last        = last_ff;

endmodule
`default_nettype wire

// ----- sv/nor_flash_command_sequencer.sv -----
// NOR flash command sequencer.
// req channel: one beat per command (program word, erase sector, read ID) or
// per flash read response. Commands arriving while an operation is in flight,
// and responses arriving while idle, are dropped without any result.
// rsp channel: bus writes, bus read requests and completion reports, with
// last set on the final beat caused by each request beat.
// APB port: poll_limit at 0x0, expected_vendor at 0x4, expected_product at 0x8;
// write only while the block is idle.
// A req beat is registered in the job queue, the back's job register and the
// output register in that order. Throughput: the front classifies one req beat
// per cycle into a 4-entry job queue; the back expands jobs into one rsp beat
// per cycle: a program gives 5 beats, an erase 7, read ID 4+1+4, a poll read 1.
// req.ready drops only while the job queue is full.
// If rsp.ready is low the output register holds its beat, the back stalls and
// the queue fills, after which req is back-pressured.
// Reset (synchronous) empties the queue, returns the sequencer to idle and
// loads the register defaults.
`default_nettype none
module nor_flash_command_sequencer #(
   parameter int unsigned WORD_ADDRESS_BITS = nfcs_pkg::WORD_ADDRESS_BITS_DEF,
   parameter int unsigned POLL_COUNT_BITS   = nfcs_pkg::POLL_COUNT_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   nfcs_req_if.sink                            req,
   nfcs_rsp_if.source                          rsp,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire [nfcs_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire [31:0]                          pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import nfcs_pkg::*;

   // seq, address, write data, status, vendor, product
   localparam int unsigned JOB_BITS = SEQ_BITS + WORD_ADDRESS_BITS + 3 * WORD_BITS + 2;

   logic [LIMIT_BITS-1:0] poll_limit_ff;
   logic [WORD_BITS-1:0]  expected_vendor_ff;
   logic [WORD_BITS-1:0]  expected_product_ff;
   nfcs_cfg_type          cfg;
   nfcs_reg_type          reg_sel;
   logic                  csr_write;

   logic                  push, pop, queue_full, queue_empty;
   logic [JOB_BITS-1:0]   push_data, queue_head;

   assign pready    = 1'b1;
   assign reg_sel   = nfcs_reg_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff       <= POLL_LIMIT_RESET;
         expected_vendor_ff  <= EXPECTED_VENDOR_RESET;
         expected_product_ff <= EXPECTED_PRODUCT_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            REG_POLL_LIMIT:       poll_limit_ff       <= pwdata[LIMIT_BITS-1:0];
            REG_EXPECTED_VENDOR:  expected_vendor_ff  <= pwdata[WORD_BITS-1:0];
            REG_EXPECTED_PRODUCT: expected_product_ff <= pwdata[WORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_POLL_LIMIT:       prdata = 32'(poll_limit_ff);
         REG_EXPECTED_VENDOR:  prdata = 32'(expected_vendor_ff);
         REG_EXPECTED_PRODUCT: prdata = 32'(expected_product_ff);
         default:              prdata = '0;
      endcase
   end

   assign cfg = '{poll_limit: poll_limit_ff, expected_vendor: expected_vendor_ff,
                  expected_product: expected_product_ff};

   nfcs_front #(
      .WORD_ADDRESS_BITS (WORD_ADDRESS_BITS),
      .POLL_COUNT_BITS   (POLL_COUNT_BITS),
      .JOB_BITS          (JOB_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   nfcs_queue #(
      .DATA_BITS (JOB_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   nfcs_back #(
      .WORD_ADDRESS_BITS (WORD_ADDRESS_BITS),
      .JOB_BITS          (JOB_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .pop         (pop),
      .rsp         (rsp)
   );

endmodule
`default_nettype wire

// ----- sim/nor_flash_command_sequencer_tb.sv -----
`timescale 1ns / 1ps
module nor_flash_command_sequencer_tb;
   import nfcs_pkg::*;

   localparam int unsigned ADDR_W          = WORD_ADDRESS_BITS_DEF;
   localparam int unsigned COUNT_W         = POLL_COUNT_BITS_DEF;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          END_CYCLES      = 12;
   localparam int          WATCHDOG_CYCLES = 3000;
   localparam int          PHASE_BEATS     = 84;

   typedef enum logic [1:0] {
      FL_IDLE,
      FL_POLL,
      FL_VENDOR,
      FL_PRODUCT
   } flash_phase_type;

   typedef struct packed {
      nfcs_kind_type        kind;
      logic [ADDR_W-1:0]    addr;
      logic [WORD_BITS-1:0] data;
      nfcs_status_type      status;
      logic [WORD_BITS-1:0] vendor;
      logic [WORD_BITS-1:0] product;
      logic                 last;
   } bus_beat_type;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   nfcs_req_if req_ch ();
   nfcs_rsp_if rsp_ch ();

   nor_flash_command_sequencer dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the sequencer and its registers
   nfcs_cfg_type         flash_cfg;
   flash_phase_type      flash_phase;
   logic [ADDR_W-1:0]    target_addr;
   logic                 prev_dq6;
   logic                 have_first_read;
   logic [COUNT_W-1:0]   poll_count;
   logic [WORD_BITS-1:0] captured_vendor;

   bus_beat_type staged_beats[$];
   bus_beat_type pending_bus_beats[$];

   bit no_idling;
   int mismatches;
   int beats_sent;
   int useful_beats;
   int results_checked;
   int csr_writes;
   int op_count[4];
   int done_count[3];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic stage_beat(input nfcs_kind_type kind, input logic [ADDR_W-1:0] addr,
                             input logic [WORD_BITS-1:0] data,
                             input nfcs_status_type status,
                             input logic [WORD_BITS-1:0] vendor,
                             input logic [WORD_BITS-1:0] product);
      bus_beat_type b;
      b.kind    = kind;
      b.addr    = addr;
      b.data    = data;
      b.status  = status;
      b.vendor  = vendor;
      b.product = product;
      b.last    = 1'b0;
      staged_beats.push_back(b);
   endtask

   task automatic stage_unlock(input logic [WORD_BITS-1:0] cmd);
      stage_beat(KIND_WRITE, ADDR_W'(UNLOCK_A), UNLOCK_DATA_A, ST_OK, '0, '0);
      stage_beat(KIND_WRITE, ADDR_W'(UNLOCK_B), UNLOCK_DATA_B, ST_OK, '0, '0);
      stage_beat(KIND_WRITE, ADDR_W'(UNLOCK_A), cmd, ST_OK, '0, '0);
   endtask

   task automatic stage_done(input nfcs_status_type status,
                             input logic [WORD_BITS-1:0] vendor,
                             input logic [WORD_BITS-1:0] product);
      stage_beat(KIND_DONE, '0, '0, status, vendor, product);
      done_count[status]++;
   endtask

   // works out the bus beats one accepted request beat causes
   task automatic predict_bus_beats(input nfcs_op_type op,
                                    input logic [OFFSET_BITS-1:0] offset,
                                    input logic [WORD_BITS-1:0] wdata,
                                    input logic [WORD_BITS-1:0] rdata);
      logic [ADDR_W-1:0] waddr;
      logic              dq6;
      nfcs_status_type   id_status;
      bus_beat_type      b;
      staged_beats.delete();
      waddr = ADDR_W'(offset >> 1);
      dq6   = rdata[DQ6_BIT];
      if (op != OP_RESPONSE) begin
         // commands are dropped unless idle
         if (flash_phase == FL_IDLE) begin
            target_addr     = waddr;
            prev_dq6        = 1'b0;
            have_first_read = 1'b0;
            poll_count      = '0;
            op_count[op]++;
            case (op)
               OP_PROGRAM: begin
                  stage_unlock(CMD_PROGRAM);
                  stage_beat(KIND_WRITE, waddr, wdata, ST_OK, '0, '0);
                  stage_beat(KIND_READ, waddr, '0, ST_OK, '0, '0);
                  flash_phase = FL_POLL;
               end
               OP_ERASE: begin
                  stage_unlock(CMD_ERASE);
                  stage_beat(KIND_WRITE, ADDR_W'(UNLOCK_A), UNLOCK_DATA_A, ST_OK, '0, '0);
                  stage_beat(KIND_WRITE, ADDR_W'(UNLOCK_B), UNLOCK_DATA_B, ST_OK, '0, '0);
                  stage_beat(KIND_WRITE, waddr, CMD_SECTOR, ST_OK, '0, '0);
                  stage_beat(KIND_READ, waddr, '0, ST_OK, '0, '0);
                  flash_phase = FL_POLL;
               end
               default: begin
                  stage_unlock(CMD_ID_ENTRY);
                  stage_beat(KIND_READ, '0, '0, ST_OK, '0, '0);
                  flash_phase = FL_VENDOR;
               end
            endcase
         end
      end else begin
         case (flash_phase)
            FL_POLL: begin
               if (have_first_read && dq6 == prev_dq6) begin
                  stage_done(ST_OK, '0, '0);
                  flash_phase     = FL_IDLE;
                  have_first_read = 1'b0;
               end else begin
                  // first response records DQ6 without advancing the poll count
                  if (have_first_read) poll_count = poll_count + 1'b1;
                  prev_dq6        = dq6;
                  have_first_read = 1'b1;
                  if (poll_count >= flash_cfg.poll_limit || poll_count == '1) begin
                     stage_done(ST_TIMEOUT, '0, '0);
                     flash_phase     = FL_IDLE;
                     have_first_read = 1'b0;
                  end else begin
                     stage_beat(KIND_READ, target_addr, '0, ST_OK, '0, '0);
                  end
               end
            end
            FL_VENDOR: begin
               captured_vendor = rdata;
               stage_beat(KIND_READ, ADDR_W'(1), '0, ST_OK, '0, '0);
               flash_phase = FL_PRODUCT;
            end
            FL_PRODUCT: begin
               id_status = (captured_vendor == flash_cfg.expected_vendor &&
                            rdata == flash_cfg.expected_product) ? ST_OK : ST_UNKNOWN;
               stage_unlock(CMD_ID_EXIT);
               stage_done(id_status, captured_vendor, rdata);
               flash_phase = FL_IDLE;
            end
            default: ;
         endcase
      end
      foreach (staged_beats[i]) begin
         b      = staged_beats[i];
         b.last = (i == staged_beats.size() - 1);
         pending_bus_beats.push_back(b);
      end
      if (staged_beats.size() != 0) useful_beats++;
   endtask

   task automatic send_flash_beat(input nfcs_op_type op,
                                  input logic [OFFSET_BITS-1:0] offset,
                                  input logic [WORD_BITS-1:0] wdata,
                                  input logic [WORD_BITS-1:0] rdata);
      int gap;
      gap = 0;
      if (!no_idling && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.byte_offset <= offset;
      req_ch.write_data  <= wdata;
      req_ch.read_data   <= rdata;
      do @(posedge clock); while (!req_ch.ready);
      predict_bus_beats(op, offset, wdata, rdata);
      beats_sent++;
   endtask

   task automatic send_response(input logic [WORD_BITS-1:0] rdata);
      send_flash_beat(OP_RESPONSE, OFFSET_BITS'($urandom), WORD_BITS'($urandom), rdata);
   endtask

   task automatic send_stray_command();
      send_flash_beat(nfcs_op_type'($urandom_range(0, 2)), OFFSET_BITS'($urandom),
                      WORD_BITS'($urandom), WORD_BITS'($urandom));
   endtask

   // register writes only once the block has gone quiet
   task automatic write_csr(input nfcs_reg_type r, input logic [31:0] value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_bus_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (r)
         REG_POLL_LIMIT:       flash_cfg.poll_limit       = value[LIMIT_BITS-1:0];
         REG_EXPECTED_VENDOR:  flash_cfg.expected_vendor  = value[WORD_BITS-1:0];
         REG_EXPECTED_PRODUCT: flash_cfg.expected_product = value[WORD_BITS-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic apply_settings(input logic [LIMIT_BITS-1:0] limit,
                                 input logic [WORD_BITS-1:0] vendor,
                                 input logic [WORD_BITS-1:0] product);
      write_csr(REG_POLL_LIMIT, 32'(limit));
      write_csr(REG_EXPECTED_VENDOR, 32'(vendor));
      write_csr(REG_EXPECTED_PRODUCT, 32'(product));
   endtask

   // answers poll reads: DQ6 flips 'toggles' times, then holds
   task automatic poll_to_completion(input int toggles, input bit strays);
      logic                 dq6;
      logic [WORD_BITS-1:0] rdata;
      dq6 = 1'($urandom);
      while (flash_phase == FL_POLL) begin
         if (strays && $urandom_range(0, 9) == 0) send_stray_command();
         rdata          = WORD_BITS'($urandom);
         rdata[DQ6_BIT] = dq6;
         send_response(rdata);
         if (toggles > 0) begin
            dq6 = ~dq6;
            toggles--;
         end
      end
   endtask

   task automatic identify_chip(input bit vendor_ok, input bit product_ok, input bit strays);
      send_flash_beat(OP_READ_ID, OFFSET_BITS'($urandom), WORD_BITS'($urandom),
                      WORD_BITS'($urandom));
      if (strays && $urandom_range(0, 7) == 0) send_stray_command();
      send_response(vendor_ok ? flash_cfg.expected_vendor : WORD_BITS'($urandom));
      if (strays && $urandom_range(0, 7) == 0) send_stray_command();
      send_response(product_ok ? flash_cfg.expected_product : WORD_BITS'($urandom));
   endtask

   task automatic test_program_word();
      send_flash_beat(OP_PROGRAM, '1, '1, '0);
      send_response(16'hFFFF);
      send_response(16'hFFBF);
      send_response(16'h0040);
      send_response(16'h0040);
   endtask

   task automatic test_erase_sector();
      send_flash_beat(OP_ERASE, '0, '1, '1);
      send_response(16'h0000);
      send_response(16'hFFFF);
      send_response(16'hFFFF);
   endtask

   task automatic test_read_id();
      identify_chip(1'b1, 1'b1, 1'b0);
      send_flash_beat(OP_READ_ID, OFFSET_BITS'(22'h155555), '0, '0);
      send_response(16'h00BE);
      send_response(flash_cfg.expected_product);
   endtask

   // response while idle, commands while busy
   task automatic test_ignored_beats();
      send_flash_beat(OP_RESPONSE, '1, '1, '1);
      send_flash_beat(OP_PROGRAM, '0, '0, '1);
      send_flash_beat(OP_ERASE, '1, '1, '0);
      send_flash_beat(OP_READ_ID, '1, '1, '1);
      send_response(16'h0000);
      send_response(16'h0000);
   endtask

   task automatic test_poll_timeout();
      apply_settings(24'd1, 16'hFFFF, 16'h0000);
      send_flash_beat(OP_PROGRAM, OFFSET_BITS'($urandom), WORD_BITS'($urandom), '0);
      send_response(16'h0000);
      send_response(16'h0040);
      identify_chip(1'b1, 1'b1, 1'b0);
   endtask

   task automatic run_mixed_traffic(input int target);
      int start;
      int pick;
      int toggles;
      start = beats_sent;
      while (beats_sent - start < target) begin
         pick    = $urandom_range(0, 19);
         toggles = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
         if (pick < 7) begin
            send_flash_beat(OP_PROGRAM, OFFSET_BITS'($urandom), WORD_BITS'($urandom),
                            WORD_BITS'($urandom));
            poll_to_completion(toggles, 1'b1);
         end else if (pick < 12) begin
            send_flash_beat(OP_ERASE, OFFSET_BITS'($urandom), WORD_BITS'($urandom),
                            WORD_BITS'($urandom));
            poll_to_completion(toggles, 1'b1);
         end else if (pick < 17) begin
            identify_chip($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, 1'b1);
         end else begin
            send_response(WORD_BITS'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic();
      apply_settings(24'hFFFFFF, WORD_BITS'($urandom), WORD_BITS'($urandom));
      run_mixed_traffic(PHASE_BEATS);
      apply_settings(24'd1, 16'h0000, 16'hFFFF);
      run_mixed_traffic(PHASE_BEATS);
      apply_settings(LIMIT_BITS'($urandom_range(2, 6)), WORD_BITS'($urandom),
                     WORD_BITS'($urandom));
      run_mixed_traffic(PHASE_BEATS);
      apply_settings(24'd3, 16'hFFFF, 16'h0000);
      run_mixed_traffic(PHASE_BEATS);
      // closing stretch at full rate on both sides
      no_idling = 1'b1;
      apply_settings(LIMIT_BITS'($urandom_range(1, 8)), WORD_BITS'($urandom),
                     WORD_BITS'($urandom));
      run_mixed_traffic(PHASE_BEATS);
   endtask

   task automatic check_bus_beat();
      bus_beat_type want;
      if (pending_bus_beats.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result beat: kind %0d addr %0h data %0h status %0d last %0b",
                     rsp_ch.item_kind, rsp_ch.bus_address, rsp_ch.bus_data, rsp_ch.status,
                     rsp_ch.last);
      end else begin
         want = pending_bus_beats.pop_front();
         results_checked++;
         if (rsp_ch.item_kind !== want.kind || rsp_ch.bus_address !== want.addr ||
             rsp_ch.bus_data !== want.data || rsp_ch.status !== want.status ||
             rsp_ch.vendor_id !== want.vendor || rsp_ch.product_id !== want.product ||
             rsp_ch.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result beat %0d mismatch at %0t", results_checked, $realtime);
               $display("  expected kind %0d addr %0h data %0h status %0d ven %0h prod %0h last %0b",
                        want.kind, want.addr, want.data, want.status, want.vendor,
                        want.product, want.last);
               $display("  actual   kind %0d addr %0h data %0h status %0d ven %0h prod %0h last %0b",
                        rsp_ch.item_kind, rsp_ch.bus_address, rsp_ch.bus_data, rsp_ch.status,
                        rsp_ch.vendor_id, rsp_ch.product_id, rsp_ch.last);
            end
         end
      end
   endtask

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_bus_beat();
         if (stall_left > 0) begin
            stall_left--;
         end else if (!no_idling && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15);
         end
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (psel && penable)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("no handshake for %0d cycles, %0d result beats still owed",
               WATCHDOG_CYCLES, pending_bus_beats.size());
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_PROGRAM;
      req_ch.byte_offset <= '0;
      req_ch.write_data  <= '0;
      req_ch.read_data   <= '0;
      no_idling       = 1'b0;
      mismatches      = 0;
      beats_sent      = 0;
      useful_beats    = 0;
      results_checked = 0;
      csr_writes      = 0;
      flash_cfg.poll_limit       = POLL_LIMIT_RESET;
      flash_cfg.expected_vendor  = EXPECTED_VENDOR_RESET;
      flash_cfg.expected_product = EXPECTED_PRODUCT_RESET;
      flash_phase     = FL_IDLE;
      target_addr     = '0;
      prev_dq6        = 1'b0;
      have_first_read = 1'b0;
      poll_count      = '0;
      captured_vendor = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_program_word();
      test_erase_sector();
      test_read_id();
      test_ignored_beats();
      test_poll_timeout();
      test_random_traffic();

      req_ch.valid <= 1'b0;
      while (pending_bus_beats.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("%0d request beats, %0d with results (%0d program, %0d erase, %0d read-ID)",
               beats_sent, useful_beats, op_count[OP_PROGRAM], op_count[OP_ERASE],
               op_count[OP_READ_ID]);
      $display("%0d result beats; completions: %0d ok, %0d timeout, %0d unknown chip; %0d csr writes",
               results_checked, done_count[ST_OK], done_count[ST_TIMEOUT],
               done_count[ST_UNKNOWN], csr_writes);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatching result beats", mismatches);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
